// File: hdl/sort_with_index_top_assert.svh
// Assertion macros for the sort-with-index block
`ifndef SORT_WITH_INDEX_TOP_ASSERT_SVH
`define SORT_WITH_INDEX_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define SWI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset
`define SWI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hdl/swi_pkg.sv
// Package with shared types for the sort-with-index block
`timescale 1ns / 1ps
package swi_pkg;
  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW = 6;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } swi_state_e;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last;
  } swi_item_t;
endpackage

// File: hdl/swi_ram.sv
// Generic RAM with one write port and one registered read port
`timescale 1ns / 1ps
module swi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: hdl/swi_front.sv
// Front end: two-entry input queue decoupling acceptance from the sorter
`timescale 1ns / 1ps
module swi_front
  import swi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [ValueW-1:0] value_i,
  input  logic             last_i,
  output logic             full_o,
  output logic             valid_o,
  output swi_item_t        item_o,
  input  logic             take_i
);
  swi_item_t  buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = buf_q[rptr_q];
  assign wr = push_i && !full_o;
  assign rd = take_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      buf_q[wptr_q] <= '{value: value_i, last: last_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr) wptr_q <= ~wptr_q;
      if (rd) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// File: hdl/swi_back.sv
// Back end: insertion-sort chain of cells, store of values, and output register
`timescale 1ns / 1ps
module swi_back
  import swi_pkg::*;
#(
  parameter int unsigned MaxLen = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              descending_i,
  input  logic              valid_i,
  input  swi_item_t         item_i,
  output logic              take_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [ValueW-1:0] sorted_value_o,
  output logic [PosW-1:0]   original_index_o,
  output logic              last_out_o,
  output logic              overflow_o
);
  localparam int unsigned AW = $clog2(MaxLen);
  localparam int unsigned CW = AW + 1;

  swi_state_e state_q, state_d;
  logic [CW-1:0] cnt_q;      // kept elements
  logic [CW-1:0] idx_q;      // sort feed / emit index
  logic          drop_q;
  logic          desc_q;
  logic          rd_pend_q;  // RAM read in flight during sort feed

  // Insertion cells: hold value and arrival address, sorted order
  logic [ValueW-1:0] cv_q [MaxLen];
  logic [AW-1:0]     ca_q [MaxLen];
  logic [MaxLen-1:0] cf_q;

  logic              ram_we;
  logic [AW-1:0]     ram_ra;
  logic [ValueW-1:0] ram_rd;
  logic [AW-1:0]     feed_a_q;

  swi_ram #(.Width(ValueW), .Depth(MaxLen)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(item_i.value),
    .raddr_i(ram_ra),
    .rdata_o(ram_rd)
  );

  // Output register
  logic              ov_q;
  logic [ValueW-1:0] osv_q;
  logic [PosW-1:0]   oidx_q;
  logic              olast_q, oovf_q;

  logic out_free;
  assign out_free = !ov_q || pop_i;
  assign empty_o = !ov_q;
  assign sorted_value_o   = osv_q;
  assign original_index_o = oidx_q;
  assign last_out_o       = olast_q;
  assign overflow_o       = oovf_q;

  assign take_o = (state_q == ST_LOAD);
  assign ram_we = take_o && valid_i && (cnt_q < CW'(MaxLen));
  assign ram_ra = idx_q[AW-1:0];

  logic feed_done;
  assign feed_done = (idx_q == cnt_q) && !rd_pend_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: if (valid_i && item_i.last) state_d = ST_SORT;
      ST_SORT: if (feed_done) state_d = (cnt_q == '0) ? ST_LOAD : ST_EMIT;
      ST_EMIT: if (out_free && (idx_q == cnt_q - CW'(1))) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  // Insertion: compare new value in all cells, shift the tail right
  logic [MaxLen-1:0] ins_before;
  always_comb begin
    for (int k = 0; k < MaxLen; k++) begin
      ins_before[k] = cf_q[k] && (desc_q ? ($signed(ram_rd) > $signed(cv_q[k]))
                                         : ($signed(ram_rd) < $signed(cv_q[k])));
    end
  end

  logic ins;
  assign ins = (state_q == ST_SORT) && rd_pend_q;

  always_ff @(posedge clk_i) begin
    if (ins) begin
      for (int k = 0; k < MaxLen; k++) begin
        if (ins_before[k]) begin
          if (k == 0 || !ins_before[k-1]) begin
            cv_q[k] <= ram_rd;
            ca_q[k] <= feed_a_q;
          end else begin
            cv_q[k] <= cv_q[k-1];
            ca_q[k] <= ca_q[k-1];
          end
        end else if (!cf_q[k] && (k == 0 || cf_q[k-1])) begin
          if (k != 0 && ins_before[k-1]) begin
            cv_q[k] <= cv_q[k-1];
            ca_q[k] <= ca_q[k-1];
          end else begin
            cv_q[k] <= ram_rd;
            ca_q[k] <= feed_a_q;
          end
        end
      end
    end else if (state_q == ST_EMIT && out_free) begin
      // Advance the chain toward cell 0
      for (int k = 0; k < MaxLen - 1; k++) begin
        cv_q[k] <= cv_q[k+1];
        ca_q[k] <= ca_q[k+1];
      end
    end
    if (state_q == ST_EMIT && out_free) begin
      osv_q   <= cv_q[0];
      oidx_q  <= PosW'(ca_q[0]);
      olast_q <= (idx_q == cnt_q - CW'(1));
      oovf_q  <= drop_q;
    end
    if (rd_pend_q) feed_a_q <= feed_a_q;
    if (state_q == ST_SORT && !rd_pend_q) feed_a_q <= idx_q[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      idx_q     <= '0;
      drop_q    <= 1'b0;
      desc_q    <= 1'b0;
      rd_pend_q <= 1'b0;
      cf_q      <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_free) ov_q <= (state_q == ST_EMIT);
      unique case (state_q)
        ST_LOAD: begin
          if (valid_i) begin
            if (ram_we) cnt_q <= cnt_q + CW'(1);
            else        drop_q <= 1'b1;
            if (item_i.last) begin
              desc_q    <= descending_i;
              idx_q     <= '0;
              rd_pend_q <= 1'b0;
              cf_q      <= '0;
            end
          end
        end
        ST_SORT: begin
          if (ins) cf_q <= {cf_q[MaxLen-2:0], 1'b1};
          // Alternate read issue and insert
          if (!rd_pend_q && idx_q != cnt_q) begin
            rd_pend_q <= 1'b1;
            idx_q     <= idx_q + CW'(1);
          end else begin
            rd_pend_q <= 1'b0;
          end
          if (feed_done) begin
            idx_q <= '0;
            if (cnt_q == '0) drop_q <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (idx_q == cnt_q - CW'(1)) begin
              idx_q  <= '0;
              cnt_q  <= '0;
              drop_q <= 1'b0;
            end else begin
              idx_q <= idx_q + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: hdl/sort_with_index_top.sv
// Top level of the sort-with-index block
`timescale 1ns / 1ps
// Stable argsort of signed 32-bit items. Items enter at one per cycle into a
// value RAM while a block loads; after the last item the sorter reads the RAM
// back one element at a time (registered RAM read, then one insertion into the
// compare-all cell chain), then drains the results at one per cycle while the
// receiver pops them. Items beyond MaxLen are dropped and flagged by overflow
// on every result of that block.
`include "sort_with_index_top_assert.svh"
module sort_with_index_top
  import swi_pkg::*;
#(
  parameter int unsigned MaxLen = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [ValueW-1:0] value_i,
  input  logic              last_i,
  output logic              empty,
  input  logic              pop,
  output logic [ValueW-1:0] sorted_value_o,
  output logic [PosW-1:0]   original_index_o,
  output logic              last_out_o,
  output logic              overflow_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i
);
  logic      desc_q;
  logic      fvalid, take;
  swi_item_t fitem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b0;
    end else if (cfg_we_i) begin
      desc_q <= cfg_wdata_i;
    end
  end

  swi_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .value_i(value_i),
    .last_i (last_i),
    .full_o (full),
    .valid_o(fvalid),
    .item_o (fitem),
    .take_i (take)
  );

  swi_back #(.MaxLen(MaxLen)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .descending_i    (desc_q),
    .valid_i         (fvalid),
    .item_i          (fitem),
    .take_o          (take),
    .empty_o         (empty),
    .pop_i           (pop),
    .sorted_value_o  (sorted_value_o),
    .original_index_o(original_index_o),
    .last_out_o      (last_out_o),
    .overflow_o      (overflow_o)
  );

  `SWI_ASSERT_NXT(a_last_starts_sort, clk_i, rst_ni, take && fvalid && fitem.last,
    u_back.state_q == ST_SORT, "sorter did not start after last item")
  `SWI_ASSERT_NXT(a_hold_result, clk_i, rst_ni, !empty && !pop,
    !empty && $stable(sorted_value_o) && $stable(original_index_o), "result changed while held")
  `SWI_ASSERT_NXT(a_cfg_write, clk_i, rst_ni, cfg_we_i,
    desc_q == $past(cfg_wdata_i), "mode register not written")
endmodule

// File: test/tb_top.sv
// Self-checking testbench for the stable signed argsort block
`timescale 1ns / 1ps

class argsort_scoreboard;
  logic [31:0] blk_values[$];
  logic [5:0]  blk_positions[$];
  bit          dropped;
  bit          desc_mode;
  logic [31:0] exp_value[$];
  logic [5:0]  exp_index[$];
  bit          exp_last[$];
  bit          exp_ovf[$];
  int          errors;
  int          results_seen;
  int          blocks_closed;
  int          overflow_blocks;

  function void note_item(logic [31:0] v, bit last);
    int n;
    int j;
    logic [31:0] sv[$];
    logic [5:0]  sp[$];
    logic [31:0] cv;
    logic [5:0]  cp;
    if (blk_values.size() < 64) begin
      blk_positions.push_back(6'(blk_values.size()));
      blk_values.push_back(v);
    end else begin
      dropped = 1;
    end
    if (!last) return;
    n = blk_values.size();
    for (int i = 0; i < n; i++) begin
      cv = blk_values[i];
      cp = blk_positions[i];
      j = sv.size();
      while (j > 0 && (desc_mode ? ($signed(cv) > $signed(sv[j-1]))
                                 : ($signed(cv) < $signed(sv[j-1]))))
        j--;
      sv.insert(j, cv);
      sp.insert(j, cp);
    end
    for (int i = 0; i < n; i++) begin
      exp_value.push_back(sv[i]);
      exp_index.push_back(sp[i]);
      exp_last.push_back(i == n - 1);
      exp_ovf.push_back(dropped);
    end
    blocks_closed++;
    if (dropped) overflow_blocks++;
    blk_values.delete();
    blk_positions.delete();
    dropped = 0;
  endfunction

  function void check_result(logic [31:0] v, logic [5:0] idx, bit lst, bit ovf);
    logic [31:0] ev;
    logic [5:0]  ei;
    bit          el;
    bit          eo;
    results_seen++;
    if (exp_value.size() == 0) begin
      $error("unexpected result value=%0d index=%0d", $signed(v), idx);
      errors++;
      return;
    end
    ev = exp_value.pop_front();
    ei = exp_index.pop_front();
    el = exp_last.pop_front();
    eo = exp_ovf.pop_front();
    if (v !== ev) begin
      $error("sorted_value expected %0d actual %0d", $signed(ev), $signed(v));
      errors++;
    end
    if (idx !== ei) begin
      $error("original_index expected %0d actual %0d", ei, idx);
      errors++;
    end
    if (lst !== el) begin
      $error("last_out expected %0b actual %0b", el, lst);
      errors++;
    end
    if (ovf !== eo) begin
      $error("overflow expected %0b actual %0b", eo, ovf);
      errors++;
    end
  endfunction

  function int pending();
    return exp_value.size();
  endfunction
endclass

module tb_top;
  import swi_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic [ValueW-1:0] value_i;
  logic              last_i;
  logic              empty;
  logic              pop;
  logic [ValueW-1:0] sorted_value_o;
  logic [PosW-1:0]   original_index_o;
  logic              last_out_o;
  logic              overflow_o;
  logic              cfg_we_i;
  logic              cfg_wdata_i;

  argsort_scoreboard sb;
  int  hold_off_cycles;
  bit  random_stall;
  bit  bursty;
  int  burst_left;
  int  items_sent;

  sort_with_index_top #(.MaxLen(64)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .value_i(value_i), .last_i(last_i), .empty(empty), .pop(pop),
    .sorted_value_o(sorted_value_o), .original_index_o(original_index_o),
    .last_out_o(last_out_o), .overflow_o(overflow_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: check on each accepted transaction, stall on its own pattern
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      sb.check_result(sorted_value_o, original_index_o, last_out_o, overflow_o);
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      pop <= 1'b0;
    end else if (random_stall) begin
      pop <= ($urandom_range(0, 3) != 0);
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic send_item(logic [31:0] v, bit last);
    if (bursty) begin
      if (burst_left == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    push    <= 1'b1;
    value_i <= v;
    last_i  <= last;
    do @(posedge clk_i); while (full);
    sb.note_item(v, last);
    items_sent++;
  endtask

  task automatic go_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_mode(bit desc);
    go_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= desc;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.desc_mode = desc;
  endtask

  function automatic logic [31:0] rand_value(int mode);
    case (mode)
      0: return $urandom_range(0, 7) - 4;
      1: return {$urandom_range(0, 1) ? 4'hF : 4'h0, 28'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  task automatic send_block(int len, int mode);
    for (int i = 0; i < len; i++)
      send_item(rand_value(mode), i == len - 1);
  endtask

  initial begin
    sb = new();
    push = 0; value_i = 0; last_i = 0; cfg_we_i = 0; cfg_wdata_i = 0;
    hold_off_cycles = 0; random_stall = 0; bursty = 0; burst_left = 0;
    items_sent = 0;
    rst_ni = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, ties, single item, both orders
    send_item(32'h7FFF_FFFF, 0);
    send_item(32'h8000_0000, 0);
    send_item(32'h0000_0000, 0);
    send_item(32'hFFFF_FFFF, 0);
    send_item(32'h0000_0001, 0);
    send_item(32'h8000_0000, 0);
    send_item(32'h7FFF_FFFF, 1);
    send_item(32'h0000_0005, 1);
    write_mode(1);
    send_item(32'h0000_0003, 0);
    send_item(32'h8000_0000, 0);
    send_item(32'h0000_0003, 0);
    send_item(32'h7FFF_FFFF, 0);
    send_item(32'hFFFF_FFFF, 1);
    send_item(32'h8000_0000, 1);
    // change mode mid-block: order follows mode at close
    send_item(32'h0000_0002, 0);
    send_item(32'h0000_0009, 0);
    go_idle();
    cfg_we_i <= 1'b1; cfg_wdata_i <= 1'b0;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.desc_mode = 0;
    send_item(32'h0000_0001, 1);

    // full block plus dropped items, last one dropped too
    write_mode(0);
    send_block(66, 2);
    write_mode(1);
    send_block(64, 0);

    // random part with idling on both sides
    random_stall = 1;
    bursty = 1;
    while (items_sent < 290) begin
      if ($urandom_range(0, 9) == 0) write_mode($urandom_range(0, 1));
      if ($urandom_range(0, 19) == 0) send_block($urandom_range(60, 68), 2);
      else send_block($urandom_range(1, 12), $urandom_range(0, 2));
    end

    // back pressure: receiver holds off while the sender keeps pushing
    go_idle();
    bursty = 0;
    hold_off_cycles = 1500;
    for (int b = 0; b < 8; b++) send_block(12, 2);
    go_idle();
    random_stall = 0;
    send_block(20, 1);

    go_idle();
    $display("Covered %0d items in %0d blocks (%0d with overflow), %0d results checked.",
             items_sent, sb.blocks_closed, sb.overflow_blocks, sb.results_seen);
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hdl
hdl/swi_pkg.sv
hdl/swi_ram.sv
hdl/swi_front.sv
hdl/swi_back.sv
hdl/sort_with_index_top.sv
test/tb_top.sv
